### rtl/assert_macros.svh
// Assertion macros used by the top level of the frame parser.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slcfp_pkg.sv
// Types and constants of the SOF/length/CRC-8 frame parser.
// No dependencies; used by slcfp_crc_unit and the top level.
package slcfp_pkg;

    localparam int RX_W  = 8;
    localparam int TS_W  = 32;
    localparam int CFG_W = 16;

    localparam logic [7:0]       SOF_MARK        = 8'hAA;
    localparam logic [7:0]       CRC_POLY        = 8'h07;
    localparam logic [7:0]       NACK_CMD        = 8'hFF;
    localparam logic [7:0]       NACK_LEN        = 8'h02;
    localparam logic [7:0]       CRC_INIT        = 8'h00;
    localparam logic [CFG_W-1:0] GAP_TIMEOUT_RST = 16'd100;

    // reply frame byte positions
    localparam logic [2:0] NACK_IDX_SOF = 3'd0;
    localparam logic [2:0] NACK_IDX_LEN = 3'd1;
    localparam logic [2:0] NACK_IDX_CMD = 3'd2;
    localparam logic [2:0] NACK_IDX_BAD = 3'd3;
    localparam logic [2:0] NACK_IDX_CRC = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CMD,
        PH_PAY,
        PH_CHK
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_GAP,
        SQ_PARSE,
        SQ_CRC,
        SQ_EMIT_RD,
        SQ_EMIT_PUT
    } t_seq_state;

    typedef struct packed {
        logic       start;
        logic [7:0] seed;
        logic [7:0] data;
    } t_crc_req;

    typedef struct packed {
        logic       done;
        logic [7:0] crc;
    } t_crc_rsp;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC state after the reply's length and command bytes
    localparam logic [7:0] NACK_SEED = crc8_byte(crc8_byte(CRC_INIT, NACK_LEN), NACK_CMD);

endpackage

### rtl/slcfp_crc_unit.sv
// Bit-serial CRC-8 (poly 0x07) unit: folds one byte into a seed, one bit a cycle.
// Depends on slcfp_pkg.
module slcfp_crc_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slcfp_pkg::t_crc_req i_req,
    output slcfp_pkg::t_crc_rsp o_rsp
);

    logic       r_busy;
    logic [2:0] r_cnt;
    logic [7:0] r_crc;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_crc <= i_req.seed ^ i_req.data;
        end else if (r_busy) begin
            r_crc <= r_crc[7] ? ((r_crc << 1) ^ slcfp_pkg::CRC_POLY) : (r_crc << 1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.crc  = r_crc;

endmodule

### rtl/sof_len_crc8_frame_parser.sv
// Top level of the SOF/length/CRC-8 frame parser.
// Depends on slcfp_pkg, slcfp_crc_unit and assert_macros.svh.
//
// Input channel (i_valid/o_stall) carries one received byte and its ms stamp.
// Frames: 0xAA, LEN (1..MAX_PAY_BYTES+1), CMD, LEN-1 payload bytes, CRC-8.
// Output channel (o_valid/i_stall) carries result items: a good frame gives
// a run of CMD then the payload bytes (dest 0); a bad CRC gives a 5-byte
// NACK reply (dest 1). o_last marks the end of a run.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes the gap
// timeout; write it only while the block is idle.
// Steps: an accepted byte passes the gap and parse states; a length, command
// or payload byte then runs the bit-serial CRC unit. The CRC byte of a good
// frame then emits its items, each through a read and a put state; a bad CRC
// byte first runs the CRC unit over the NACK reply. o_stall is high from
// acceptance until the byte is done or its last item is loaded into the
// output register. The output register holds while i_stall is high; the next
// byte may be accepted while the final item still waits there.
// Reset: synchronous, active low; parser hunts for 0xAA, timeout is 100 ms.
`include "assert_macros.svh"

module sof_len_crc8_frame_parser #(
    parameter int MAX_PAY_BYTES = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic [slcfp_pkg::RX_W-1:0]                i_rx_byte,
    input  logic [slcfp_pkg::TS_W-1:0]                i_arrival_ms,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic                                      o_dest,
    output logic [7:0]                                o_data,
    output logic [$clog2(MAX_PAY_BYTES+1)-1:0]        o_pay_count,
    output logic                                      o_last,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [slcfp_pkg::CFG_W-1:0]               i_cfg_data
);

    localparam int MAX_LEN = MAX_PAY_BYTES + 1;
    localparam int LEN_W   = $clog2(MAX_PAY_BYTES + 2);
    localparam int CNT_W   = $clog2(MAX_PAY_BYTES + 1);
    localparam int ADDR_W  = (MAX_PAY_BYTES > 1) ? $clog2(MAX_PAY_BYTES) : 1;
    localparam int IDX_W   = (CNT_W > 3) ? CNT_W : 3;

    slcfp_pkg::t_seq_state r_state, n_state;
    slcfp_pkg::t_phase     r_phase, n_phase;

    logic [slcfp_pkg::CFG_W-1:0] r_timeout;
    logic [slcfp_pkg::TS_W-1:0]  r_last_arr;
    logic [slcfp_pkg::TS_W-1:0]  r_arr;
    logic [slcfp_pkg::TS_W-1:0]  r_gap;
    logic [7:0]                  r_byte;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [7:0]                  r_cmd, n_cmd;
    logic [CNT_W-1:0]            r_rcv, n_rcv;
    logic [7:0]                  r_crc;
    logic                        r_nack, n_nack;
    logic [IDX_W-1:0]            r_idx, n_idx;

    logic [7:0] r_mem [MAX_PAY_BYTES];
    logic [7:0] r_rd_data;

    logic                 r_o_valid;
    logic                 r_o_dest;
    logic [7:0]           r_o_data;
    logic [CNT_W-1:0]     r_o_count;
    logic                 r_o_last;

    slcfp_pkg::t_crc_req w_crc_req;
    slcfp_pkg::t_crc_rsp w_crc_rsp;

    logic                 w_accept;
    logic                 w_out_free;
    slcfp_pkg::t_phase    w_eff_phase;
    logic                 w_len_bad;
    logic                 w_crc_ok;
    logic [LEN_W-1:0]     w_len_m1;
    logic [CNT_W-1:0]     w_pc;
    logic [LEN_W-1:0]     w_rcv_inc;
    logic                 w_mem_we;
    logic [IDX_W-1:0]     w_idx_m1;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_emit_last;
    logic                 w_load;
    logic                 w_o_dest;
    logic [7:0]           w_o_data;
    logic [CNT_W-1:0]     w_o_count;

    slcfp_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_crc_req),
        .o_rsp   (w_crc_rsp)
    );

    assign o_stall     = (r_state != slcfp_pkg::SQ_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;

    assign w_eff_phase = (r_phase != slcfp_pkg::PH_HUNT &&
                          r_gap > {{(slcfp_pkg::TS_W-slcfp_pkg::CFG_W){1'b0}}, r_timeout})
                         ? slcfp_pkg::PH_HUNT : r_phase;
    assign w_len_bad   = (r_byte == 8'd0) || (int'(r_byte) > MAX_LEN);
    assign w_crc_ok    = (r_byte == r_crc);
    assign w_len_m1    = r_len - LEN_W'(1);
    assign w_pc        = w_len_m1[CNT_W-1:0];
    assign w_rcv_inc   = LEN_W'(r_rcv) + LEN_W'(1);
    assign w_idx_m1    = r_idx - IDX_W'(1);
    assign w_rd_addr   = (r_idx == '0) ? '0 : w_idx_m1[ADDR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slcfp_pkg::SQ_IDLE: begin
                if (w_accept) n_state = slcfp_pkg::SQ_GAP;
            end
            slcfp_pkg::SQ_GAP: n_state = slcfp_pkg::SQ_PARSE;
            slcfp_pkg::SQ_PARSE: begin
                case (w_eff_phase)
                    slcfp_pkg::PH_LEN:
                        n_state = w_len_bad ? slcfp_pkg::SQ_IDLE : slcfp_pkg::SQ_CRC;
                    slcfp_pkg::PH_CMD, slcfp_pkg::PH_PAY:
                        n_state = slcfp_pkg::SQ_CRC;
                    slcfp_pkg::PH_CHK:
                        n_state = w_crc_ok ? slcfp_pkg::SQ_EMIT_RD : slcfp_pkg::SQ_CRC;
                    default: n_state = slcfp_pkg::SQ_IDLE;
                endcase
            end
            slcfp_pkg::SQ_CRC: begin
                if (w_crc_rsp.done) n_state = r_nack ? slcfp_pkg::SQ_EMIT_RD : slcfp_pkg::SQ_IDLE;
            end
            slcfp_pkg::SQ_EMIT_RD: n_state = slcfp_pkg::SQ_EMIT_PUT;
            slcfp_pkg::SQ_EMIT_PUT: begin
                if (w_out_free) n_state = w_emit_last ? slcfp_pkg::SQ_IDLE : slcfp_pkg::SQ_EMIT_RD;
            end
            default: n_state = slcfp_pkg::SQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_rcv     = r_rcv;
        n_nack    = r_nack;
        n_idx     = r_idx;
        w_mem_we  = 1'b0;
        w_crc_req = '{start: 1'b0, seed: slcfp_pkg::CRC_INIT, data: r_byte};
        case (r_state)
            slcfp_pkg::SQ_PARSE: begin
                n_nack = 1'b0;
                n_idx  = '0;
                case (w_eff_phase)
                    slcfp_pkg::PH_HUNT: begin
                        n_phase = (r_byte == slcfp_pkg::SOF_MARK) ? slcfp_pkg::PH_LEN
                                                                  : slcfp_pkg::PH_HUNT;
                    end
                    slcfp_pkg::PH_LEN: begin
                        if (w_len_bad) begin
                            n_phase = slcfp_pkg::PH_HUNT;
                        end else begin
                            n_len           = r_byte[LEN_W-1:0];
                            n_phase         = slcfp_pkg::PH_CMD;
                            w_crc_req.start = 1'b1;
                        end
                    end
                    slcfp_pkg::PH_CMD: begin
                        n_cmd           = r_byte;
                        n_rcv           = '0;
                        n_phase         = (r_len <= LEN_W'(1)) ? slcfp_pkg::PH_CHK
                                                              : slcfp_pkg::PH_PAY;
                        w_crc_req.start = 1'b1;
                        w_crc_req.seed  = r_crc;
                    end
                    slcfp_pkg::PH_PAY: begin
                        w_mem_we        = 1'b1;
                        n_rcv           = w_rcv_inc[CNT_W-1:0];
                        if (w_rcv_inc + LEN_W'(1) >= r_len) n_phase = slcfp_pkg::PH_CHK;
                        w_crc_req.start = 1'b1;
                        w_crc_req.seed  = r_crc;
                    end
                    slcfp_pkg::PH_CHK: begin
                        n_phase = slcfp_pkg::PH_HUNT;
                        if (!w_crc_ok) begin
                            n_nack          = 1'b1;
                            w_crc_req.start = 1'b1;
                            w_crc_req.seed  = slcfp_pkg::NACK_SEED;
                        end
                    end
                    default: n_phase = slcfp_pkg::PH_HUNT;
                endcase
            end
            slcfp_pkg::SQ_EMIT_PUT: begin
                if (w_out_free) n_idx = r_idx + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // item being emitted
    always_comb begin
        if (r_nack) begin
            w_o_dest    = 1'b1;
            w_o_count   = '0;
            w_emit_last = (r_idx == IDX_W'(slcfp_pkg::NACK_IDX_CRC));
            if (r_idx == IDX_W'(slcfp_pkg::NACK_IDX_SOF))      w_o_data = slcfp_pkg::SOF_MARK;
            else if (r_idx == IDX_W'(slcfp_pkg::NACK_IDX_LEN)) w_o_data = slcfp_pkg::NACK_LEN;
            else if (r_idx == IDX_W'(slcfp_pkg::NACK_IDX_CMD)) w_o_data = slcfp_pkg::NACK_CMD;
            else if (r_idx == IDX_W'(slcfp_pkg::NACK_IDX_BAD)) w_o_data = r_byte;
            else                                               w_o_data = r_crc;
        end else begin
            w_o_dest    = 1'b0;
            w_o_count   = w_pc;
            w_emit_last = (r_idx == IDX_W'(w_pc));
            w_o_data    = (r_idx == '0) ? r_cmd : r_rd_data;
        end
    end

    assign w_load = (r_state == slcfp_pkg::SQ_EMIT_PUT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= slcfp_pkg::SQ_IDLE;
            r_phase    <= slcfp_pkg::PH_HUNT;
            r_timeout  <= slcfp_pkg::GAP_TIMEOUT_RST;
            r_last_arr <= '0;
            r_len      <= '0;
            r_cmd      <= '0;
            r_rcv      <= '0;
            r_nack     <= 1'b0;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_rcv   <= n_rcv;
            r_nack  <= n_nack;
            r_idx   <= n_idx;
            if (i_cfg_valid) r_timeout <= i_cfg_data;
            if (r_state == slcfp_pkg::SQ_GAP) r_last_arr <= r_arr;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_rx_byte;
            r_arr  <= i_arrival_ms;
        end
        if (r_state == slcfp_pkg::SQ_GAP) r_gap <= r_arr - r_last_arr;
        if (r_state == slcfp_pkg::SQ_CRC && w_crc_rsp.done) r_crc <= w_crc_rsp.crc;
        if (w_load) begin
            r_o_dest  <= w_o_dest;
            r_o_data  <= w_o_data;
            r_o_count <= w_o_count;
            r_o_last  <= w_emit_last;
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_rcv[ADDR_W-1:0]] <= r_byte;
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_valid         = r_o_valid;
    assign o_dest          = r_o_dest;
    assign o_data          = r_o_data;
    assign o_pay_count     = r_o_count;
    assign o_last          = r_o_last;

    `SLC_ASSERT_IMP(a_crc_done_in_crc, i_clk, i_rst_n, w_crc_rsp.done,
        r_state == slcfp_pkg::SQ_CRC, "CRC unit finished outside its wait state")
    `SLC_ASSERT_IMP(a_pay_bound, i_clk, i_rst_n, r_phase == slcfp_pkg::PH_PAY,
        w_rcv_inc < r_len, "payload count ran past frame length")
    `SLC_ASSERT_IMP(a_emit_idx, i_clk, i_rst_n, r_state == slcfp_pkg::SQ_EMIT_PUT && !r_nack,
        r_idx <= IDX_W'(w_pc), "emit index beyond payload count")
    `SLC_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, w_load && w_emit_last,
        r_state == slcfp_pkg::SQ_IDLE, "sequencer busy after final item")

endmodule

### test/slcfp_frame_checker.sv
// Checker for the SOF/length/CRC-8 frame parser: watches the byte, config and
// result channels, predicts every result item and compares it field by field.
// Depends on slcfp_pkg.
module slcfp_frame_checker #(
    parameter int MAX_PAY = 16,
    parameter int CNT_W   = $clog2(MAX_PAY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [slcfp_pkg::RX_W-1:0]  i_rx_byte,
    input  logic [slcfp_pkg::TS_W-1:0]  i_arrival_ms,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [slcfp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_dest,
    input  logic [7:0]                  i_data,
    input  logic [CNT_W-1:0]            i_pay_count,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_items_due
);

    typedef struct packed {
        logic             dest;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_out_item;

    t_out_item                   items_due_q[$];
    slcfp_pkg::t_phase           phase;
    logic [4:0]                  frame_len;
    logic [7:0]                  cmd_byte;
    logic [7:0]                  pay_mem [MAX_PAY];
    logic [4:0]                  pay_rcvd;
    logic [slcfp_pkg::TS_W-1:0]  last_ms;
    logic [slcfp_pkg::CFG_W-1:0] gap_timeout;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ slcfp_pkg::CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic void add_due(input logic dest, input logic [7:0] data,
                                    input int count, input logic last);
        t_out_item it;
        it.dest  = dest;
        it.data  = data;
        it.count = CNT_W'(count);
        it.last  = last;
        items_due_q.push_back(it);
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b, input logic [slcfp_pkg::TS_W-1:0] now);
        logic [slcfp_pkg::TS_W-1:0] gap;
        logic [7:0]                 crc;
        int                         pc;
        gap = now - last_ms;
        if (phase != slcfp_pkg::PH_HUNT && gap > {16'd0, gap_timeout}) phase = slcfp_pkg::PH_HUNT;
        last_ms = now;
        case (phase)
            slcfp_pkg::PH_HUNT: begin
                if (b == slcfp_pkg::SOF_MARK) phase = slcfp_pkg::PH_LEN;
            end
            slcfp_pkg::PH_LEN: begin
                if (b == 8'd0 || b > MAX_PAY + 1) begin
                    phase = slcfp_pkg::PH_HUNT;
                end else begin
                    frame_len = b[4:0];
                    phase = slcfp_pkg::PH_CMD;
                end
            end
            slcfp_pkg::PH_CMD: begin
                cmd_byte = b;
                pay_rcvd = 5'd0;
                phase = (frame_len <= 1) ? slcfp_pkg::PH_CHK : slcfp_pkg::PH_PAY;
            end
            slcfp_pkg::PH_PAY: begin
                if (pay_rcvd < MAX_PAY) pay_mem[pay_rcvd] = b;
                pay_rcvd = pay_rcvd + 5'd1;
                if (pay_rcvd + 1 >= frame_len) phase = slcfp_pkg::PH_CHK;
            end
            slcfp_pkg::PH_CHK: begin
                pc = (frame_len >= 1) ? int'(frame_len) - 1 : 0;
                if (pc > MAX_PAY) pc = MAX_PAY;
                crc = crc8_step(slcfp_pkg::CRC_INIT, 8'(frame_len));
                crc = crc8_step(crc, cmd_byte);
                for (int i = 0; i < pc; i++) crc = crc8_step(crc, pay_mem[i]);
                if (b == crc) begin
                    add_due(1'b0, cmd_byte, pc, pc == 0);
                    for (int i = 0; i < pc; i++) add_due(1'b0, pay_mem[i], pc, i + 1 == pc);
                end else begin
                    crc = crc8_step(crc8_step(crc8_step(slcfp_pkg::CRC_INIT,
                                                        slcfp_pkg::NACK_LEN),
                                              slcfp_pkg::NACK_CMD), b);
                    add_due(1'b1, slcfp_pkg::SOF_MARK, 0, 1'b0);
                    add_due(1'b1, slcfp_pkg::NACK_LEN, 0, 1'b0);
                    add_due(1'b1, slcfp_pkg::NACK_CMD, 0, 1'b0);
                    add_due(1'b1, b, 0, 1'b0);
                    add_due(1'b1, crc, 0, 1'b1);
                end
                phase = slcfp_pkg::PH_HUNT;
            end
            default: phase = slcfp_pkg::PH_HUNT;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            items_due_q.delete();
            phase        = slcfp_pkg::PH_HUNT;
            frame_len    = 5'd0;
            cmd_byte     = 8'd0;
            pay_rcvd     = 5'd0;
            last_ms      = '0;
            gap_timeout  = slcfp_pkg::GAP_TIMEOUT_RST;
            o_fail_count = 0;
            for (int i = 0; i < MAX_PAY; i++) pay_mem[i] = 8'd0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (items_due_q.size() == 0) begin
                    $error("result item with nothing expected: data %02h", i_data);
                    o_fail_count++;
                end else begin
                    exp_item = items_due_q.pop_front();
                    if (i_dest !== exp_item.dest) begin
                        $error("dest: expected %0d, actual %0d", exp_item.dest, i_dest);
                        o_fail_count++;
                    end
                    if (i_data !== exp_item.data) begin
                        $error("data: expected %02h, actual %02h", exp_item.data, i_data);
                        o_fail_count++;
                    end
                    if (i_pay_count !== exp_item.count) begin
                        $error("pay_count: expected %0d, actual %0d",
                               exp_item.count, i_pay_count);
                        o_fail_count++;
                    end
                    if (i_last !== exp_item.last) begin
                        $error("last: expected %0d, actual %0d", exp_item.last, i_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) gap_timeout = i_cfg_data;
            if (i_in_valid && !i_in_stall) parse_rx_byte(i_rx_byte, i_arrival_ms);
        end
        o_items_due = items_due_q.size();
    end

endmodule

### test/tb_sof_len_crc8_frame_parser.sv
// Testbench top for the SOF/length/CRC-8 frame parser: resets the block, sends
// directed and random frames, noise and broken frames under several timeouts.
// Depends on slcfp_pkg, the parser RTL and slcfp_frame_checker.
module tb_sof_len_crc8_frame_parser;

    localparam int MAX_PAY = 16;
    localparam int CNT_W   = $clog2(MAX_PAY + 1);

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [slcfp_pkg::RX_W-1:0]  i_rx_byte;
    logic [slcfp_pkg::TS_W-1:0]  i_arrival_ms;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_dest;
    logic [7:0]                  o_data;
    logic [CNT_W-1:0]            o_pay_count;
    logic                        o_last;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [slcfp_pkg::CFG_W-1:0] i_cfg_data;

    int                          fail_count;
    int                          items_due;
    int                          items_sent;
    logic [slcfp_pkg::TS_W-1:0]  ms_now;
    logic [slcfp_pkg::CFG_W-1:0] cur_timeout;
    bit                          tx_steady;
    bit                          rx_steady;
    bit                          long_hold;
    bit                          need_resync;

    sof_len_crc8_frame_parser #(
        .MAX_PAY_BYTES(MAX_PAY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_arrival_ms   (i_arrival_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest         (o_dest),
        .o_data         (o_data),
        .o_pay_count    (o_pay_count),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    slcfp_frame_checker #(
        .MAX_PAY(MAX_PAY)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_arrival_ms   (i_arrival_ms),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_dest         (o_dest),
        .i_data         (o_data),
        .i_pay_count    (o_pay_count),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_items_due    (items_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #36_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [slcfp_pkg::TS_W-1:0] in_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return {16'd0, cur_timeout};
        if (r < 7) return $urandom_range(0, (cur_timeout < 20) ? cur_timeout : 20);
        return $urandom_range(0, cur_timeout);
    endfunction

    function automatic logic [slcfp_pkg::TS_W-1:0] late_gap();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return {16'd0, cur_timeout} + 32'd1 + $urandom_range(0, 1000);
    endfunction

    function automatic logic [7:0] frame_crc(input logic [7:0] seq[$]);
        logic [7:0] crc;
        crc = slcfp_pkg::CRC_INIT;
        for (int i = 1; i < seq.size(); i++) crc = slcfp_pkg::crc8_byte(crc, seq[i]);
        return crc;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [slcfp_pkg::TS_W-1:0] delta,
                             input bit counted);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ms_now = ms_now + delta;
        i_valid      <= 1'b1;
        i_rx_byte    <= b;
        i_arrival_ms <= ms_now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (counted) items_sent++;
    endtask

    task automatic send_fixed(input logic [7:0] seq[$], input logic [slcfp_pkg::TS_W-1:0] delta);
        foreach (seq[i]) send_byte(seq[i], delta, 1'b1);
    endtask

    // cut: number of bytes sent (0 = whole frame); late_idx: byte sent after a timeout gap
    task automatic send_rand_frame(input int len, input bit corrupt, input int cut,
                                   input int late_idx, input bit late_first);
        logic [7:0]                 seq[$];
        logic [slcfp_pkg::TS_W-1:0] d;
        int                         n;
        seq = {slcfp_pkg::SOF_MARK, 8'(len), 8'($urandom)};
        repeat (len - 1) seq.push_back(8'($urandom));
        seq.push_back(frame_crc(seq) ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00));
        n = (cut > 0 && cut < seq.size()) ? cut : seq.size();
        for (int i = 0; i < n; i++) begin
            d = (i == late_idx || (i == 0 && late_first)) ? late_gap() : in_gap();
            send_byte(seq[i], d, 1'b1);
        end
    endtask

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end while (items_due != 0);
    endtask

    task automatic write_timeout(input logic [slcfp_pkg::CFG_W-1:0] v);
        // a byte with no result may still be in the parser
        repeat (30) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_timeout = v;
    endtask

    initial begin : rx_hold_gen
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (idle_len()) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
        end
    end

    initial begin : stimulus
        logic [7:0]                  seq[$];
        logic [slcfp_pkg::CFG_W-1:0] timeouts[5];
        int                          phase_end;
        int                          sel;
        int                          r;
        int                          len;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_byte    = '0;
        i_arrival_ms = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        ms_now       = '0;
        cur_timeout  = slcfp_pkg::GAP_TIMEOUT_RST;
        items_sent   = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        long_hold    = 1'b0;
        need_resync  = 1'b0;
        timeouts[0]  = 16'd0;
        timeouts[1]  = 16'hFFFF;
        timeouts[2]  = 16'($urandom_range(2, 5000));
        timeouts[3]  = 16'd1;
        timeouts[4]  = 16'($urandom);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise, shortest frame, bad lengths, bad CRC, timeout, wrap
        send_byte(8'h55, 32'd7, 1'b0);
        seq = {slcfp_pkg::SOF_MARK, 8'h01, 8'h00};
        seq.push_back(frame_crc(seq));
        send_fixed(seq, 32'd0);
        send_fixed({slcfp_pkg::SOF_MARK, 8'h00}, 32'd1);
        send_fixed({slcfp_pkg::SOF_MARK, 8'h12}, 32'd1);
        seq = {slcfp_pkg::SOF_MARK, 8'h03, 8'hFF, 8'h00, 8'hFF};
        seq.push_back(frame_crc(seq) ^ 8'h5A);
        send_fixed(seq, 32'd100);
        send_byte(slcfp_pkg::SOF_MARK, 32'd1, 1'b1);
        send_byte(8'h02, 32'd1, 1'b1);
        seq = {slcfp_pkg::SOF_MARK, 8'h01, 8'h5C};
        seq.push_back(frame_crc(seq));
        send_byte(slcfp_pkg::SOF_MARK, 32'd101, 1'b1);
        send_fixed(seq[1:3], 32'd2);
        send_byte(8'h00, 32'hFFFF_FFFC - ms_now, 1'b0);
        seq = {slcfp_pkg::SOF_MARK, 8'h01, 8'hC3};
        seq.push_back(frame_crc(seq));
        send_fixed(seq, 32'd2);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drain();
                write_timeout(timeouts[p-1]);
            end
            if (p == 2) long_hold = 1'b1;
            phase_end = items_sent + 76;
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                r   = $urandom_range(0, 9);
                len = (r < 6) ? $urandom_range(1, 4) : (r < 9) ? $urandom_range(5, 16) : 17;
                if (sel < 65) begin
                    send_rand_frame(len, $urandom_range(0, 4) == 0, 0, -1,
                                    need_resync || $urandom_range(0, 3) == 0);
                    need_resync = 1'b0;
                end else if (sel < 73) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), in_gap(), 1'b0);
                    need_resync = 1'b1;
                end else if (sel < 83) begin
                    send_byte(slcfp_pkg::SOF_MARK, need_resync ? late_gap() : in_gap(), 1'b1);
                    send_byte(($urandom_range(0, 1) == 0) ? 8'h00 :
                              8'($urandom_range(18, 255)), in_gap(), 1'b1);
                    need_resync = 1'b0;
                end else if (sel < 92) begin
                    send_rand_frame(len, 1'b0, $urandom_range(1, len + 2), -1, need_resync);
                    need_resync = 1'b1;
                end else begin
                    send_rand_frame(len, 1'b0, 0, $urandom_range(1, len + 2), need_resync);
                    need_resync = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drain();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && items_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
